>>> design/bmhq_pkg.sv
// ----------------------------------------------------------------------------
// bmhq_pkg
// Shared types and constants of the binary max-heap queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bmhq_pkg;

    localparam int DEF_CAPACITY = 1024;
    localparam int DATA_W       = 32;
    localparam int COUNT_OUT_W  = 11;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic signed [DATA_W-1:0] pri;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    typedef struct packed {
        t_status                  status;
        logic signed [DATA_W-1:0] removed_x;
        logic signed [DATA_W-1:0] removed_y;
        logic signed [DATA_W-1:0] head_x;
        logic signed [DATA_W-1:0] head_y;
        logic [COUNT_OUT_W-1:0]   count;
        logic                     empty;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_EV,
        S_DN_FETCH,
        S_DN_RD,
        S_DN_EV,
        S_HD_RD,
        S_HD_EV
    } t_state;

endpackage

`default_nettype wire

>>> design/bmhq_mem.sv
// ----------------------------------------------------------------------------
// bmhq_mem
// Heap store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_mem
    import bmhq_pkg::*;
#(
    parameter int DEPTH = DEF_CAPACITY,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_entry        i_wdata,
    input  wire logic          i_re,
    input  wire logic [AW-1:0] i_raddr_a,
    input  wire logic [AW-1:0] i_raddr_b,
    output t_entry             o_rdata_a,
    output t_entry             o_rdata_b
);

    t_entry r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule

`default_nettype wire

>>> design/bmhq_ctrl.sv
// ----------------------------------------------------------------------------
// bmhq_ctrl
// Sequencer for insert (sift up) and remove (sift down) over the heap store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_ctrl
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY,
    localparam int AW      = $clog2(CAPACITY),
    localparam int CW      = $clog2(CAPACITY + 1),
    localparam int KW      = AW + 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // item in
    input  wire logic                     i_start,
    input  wire logic                     i_mode,
    input  wire t_entry                   i_entry,
    output logic                          o_idle,
    // result out
    input  wire logic                     i_res_free,
    output logic                          o_done,
    output t_result                       o_res,
    // store
    output logic                          o_we,
    output logic [AW-1:0]                 o_waddr,
    output t_entry                        o_wdata,
    output logic                          o_re,
    output logic [AW-1:0]                 o_raddr_a,
    output logic [AW-1:0]                 o_raddr_b,
    input  wire t_entry                   i_rdata_a,
    input  wire t_entry                   i_rdata_b
);

    t_state                   r_state, n_state;
    logic [CW-1:0]            r_count, n_count;
    logic [AW-1:0]            r_node,  n_node;
    t_entry                   r_cur,   n_cur;
    t_status                  r_status, n_status;
    logic signed [DATA_W-1:0] r_rem_x, n_rem_x;
    logic signed [DATA_W-1:0] r_rem_y, n_rem_y;

    logic [AW-1:0] w_node_m1;
    logic [AW-1:0] w_parent;
    logic [AW-1:0] w_last;
    logic [KW-1:0] w_kid;
    logic [KW-1:0] w_kid1;
    logic [KW-1:0] w_count_k;
    logic          w_full;
    logic          w_take_b;
    t_entry        w_pick;
    logic [AW-1:0] w_pick_idx;

    assign w_node_m1 = r_node - AW'(1);
    assign w_parent  = w_node_m1 >> 1;
    assign w_last    = AW'(r_count - CW'(1));
    assign w_kid     = {1'b0, r_node, 1'b1};
    assign w_kid1    = w_kid + KW'(1);
    assign w_count_k = KW'(r_count);
    assign w_full    = (r_count == CW'(CAPACITY));

    // right child only when it exists and is strictly greater
    assign w_take_b   = (w_kid1 < w_count_k) &&
                        ($signed(i_rdata_a.pri) < $signed(i_rdata_b.pri));
    assign w_pick     = w_take_b ? i_rdata_b : i_rdata_a;
    assign w_pick_idx = w_take_b ? w_kid1[AW-1:0] : w_kid[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_node   <= n_node;
        r_cur    <= n_cur;
        r_status <= n_status;
        r_rem_x  <= n_rem_x;
        r_rem_y  <= n_rem_y;
    end

    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_node    = r_node;
        n_cur     = r_cur;
        n_status  = r_status;
        n_rem_x   = r_rem_x;
        n_rem_y   = r_rem_y;
        o_idle    = 1'b0;
        o_done    = 1'b0;
        o_we      = 1'b0;
        o_waddr   = r_node;
        o_wdata   = r_cur;
        o_re      = 1'b0;
        o_raddr_a = '0;
        o_raddr_b = '0;

        o_res.status    = r_status;
        o_res.removed_x = r_rem_x;
        o_res.removed_y = r_rem_y;
        o_res.head_x    = (r_count != '0) ? i_rdata_a.x : '0;
        o_res.head_y    = (r_count != '0) ? i_rdata_a.y : '0;
        o_res.count     = COUNT_OUT_W'(r_count);
        o_res.empty     = (r_count == '0);

        case (r_state)
            S_IDLE: begin
                o_idle = 1'b1;
                if (i_start) begin
                    n_rem_x  = '0;
                    n_rem_y  = '0;
                    n_status = ST_DONE;
                    if (!i_mode) begin
                        if (w_full) begin
                            n_status = ST_FULL;
                            n_state  = S_HD_RD;
                        end else begin
                            n_node  = AW'(r_count);
                            n_cur   = i_entry;
                            n_count = r_count + CW'(1);
                            n_state = S_UP_RD;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = ST_EMPTY;
                            n_state  = S_HD_RD;
                        end else begin
                            o_re      = 1'b1;
                            o_raddr_a = '0;
                            o_raddr_b = w_last;
                            n_state   = S_DN_FETCH;
                        end
                    end
                end
            end

            S_UP_RD: begin
                if (r_node == '0) begin
                    o_we    = 1'b1;
                    n_state = S_HD_RD;
                end else begin
                    o_re      = 1'b1;
                    o_raddr_a = w_parent;
                    n_state   = S_UP_EV;
                end
            end

            S_UP_EV: begin
                o_we = 1'b1;
                if ($signed(i_rdata_a.pri) > $signed(r_cur.pri)) begin
                    n_state = S_HD_RD;
                end else begin
                    // parent moves down into the hole
                    o_wdata = i_rdata_a;
                    n_node  = w_parent;
                    n_state = S_UP_RD;
                end
            end

            S_DN_FETCH: begin
                n_rem_x = i_rdata_a.x;
                n_rem_y = i_rdata_a.y;
                n_cur   = i_rdata_b;
                n_node  = '0;
                n_count = r_count - CW'(1);
                n_state = (r_count == CW'(1)) ? S_HD_RD : S_DN_RD;
            end

            S_DN_RD: begin
                if (w_kid >= w_count_k) begin
                    o_we    = 1'b1;
                    n_state = S_HD_RD;
                end else begin
                    o_re      = 1'b1;
                    o_raddr_a = w_kid[AW-1:0];
                    o_raddr_b = w_kid1[AW-1:0];
                    n_state   = S_DN_EV;
                end
            end

            S_DN_EV: begin
                o_we = 1'b1;
                if ($signed(r_cur.pri) >= $signed(w_pick.pri)) begin
                    n_state = S_HD_RD;
                end else begin
                    // larger child moves up into the hole
                    o_wdata = w_pick;
                    n_node  = w_pick_idx;
                    n_state = S_DN_RD;
                end
            end

            S_HD_RD: begin
                o_re      = 1'b1;
                o_raddr_a = '0;
                n_state   = S_HD_EV;
            end

            S_HD_EV: begin
                if (i_res_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> design/binary_max_heap_queue_core.sv
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core
// Binary max-heap priority queue of (x, y, priority) entries.
// ----------------------------------------------------------------------------
// One item at a time. The heap lives in a single RAM with two read ports and
// registered read data; each level of a sift issues a read, then compares and
// writes back, and a final read of the root ends every item, rejected ones
// too. The result register lets the next item be taken while a result waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_max_heap_queue_core
    import bmhq_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_in_valid,
    output logic                          o_in_ready,
    input  wire logic                     i_mode,
    input  wire logic signed [DATA_W-1:0] i_entry_x,
    input  wire logic signed [DATA_W-1:0] i_entry_y,
    input  wire logic signed [DATA_W-1:0] i_entry_priority,
    output logic                          o_out_valid,
    input  wire logic                     i_out_ready,
    output logic [1:0]                    o_status,
    output logic signed [DATA_W-1:0]      o_removed_x,
    output logic signed [DATA_W-1:0]      o_removed_y,
    output logic signed [DATA_W-1:0]      o_head_x,
    output logic signed [DATA_W-1:0]      o_head_y,
    output logic [COUNT_OUT_W-1:0]        o_entry_count,
    output logic                          o_is_empty
);

    localparam int AW = $clog2(CAPACITY);

    t_entry        w_entry;
    logic          w_idle;
    logic          w_done;
    t_result       w_res;
    logic          w_res_free;
    logic          w_we;
    logic [AW-1:0] w_waddr;
    t_entry        w_wdata;
    logic          w_re;
    logic [AW-1:0] w_raddr_a;
    logic [AW-1:0] w_raddr_b;
    t_entry        w_rdata_a;
    t_entry        w_rdata_b;

    logic          r_out_valid;
    t_result       r_out;

    assign w_entry.x   = i_entry_x;
    assign w_entry.y   = i_entry_y;
    assign w_entry.pri = i_entry_priority;
    assign o_in_ready  = w_idle;
    assign w_res_free  = !r_out_valid || i_out_ready;

    bmhq_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_in_valid && w_idle),
        .i_mode     (i_mode),
        .i_entry    (w_entry),
        .o_idle     (w_idle),
        .i_res_free (w_res_free),
        .o_done     (w_done),
        .o_res      (w_res),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_re       (w_re),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .i_rdata_a  (w_rdata_a),
        .i_rdata_b  (w_rdata_b)
    );

    bmhq_mem #(
        .DEPTH (CAPACITY)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_re),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out.status;
    assign o_removed_x   = r_out.removed_x;
    assign o_removed_y   = r_out.removed_y;
    assign o_head_x      = r_out.head_x;
    assign o_head_y      = r_out.head_y;
    assign o_entry_count = r_out.count;
    assign o_is_empty    = r_out.empty;

endmodule

`default_nettype wire

>>> design/bmhq_chk.sv
// ----------------------------------------------------------------------------
// bmhq_chk
// Port-level checks of the heap queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bmhq_chk
    import bmhq_pkg::*;
(
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     o_out_valid,
    input wire logic                     i_out_ready,
    input wire logic [1:0]               o_status,
    input wire logic signed [DATA_W-1:0] o_removed_x,
    input wire logic signed [DATA_W-1:0] o_removed_y,
    input wire logic signed [DATA_W-1:0] o_head_x,
    input wire logic signed [DATA_W-1:0] o_head_y,
    input wire logic                     o_is_empty
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) &&
            $stable(o_head_x) && $stable(o_removed_x))
        else $error("stalled result changed");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_DONE || o_status == ST_FULL ||
            o_status == ST_EMPTY))
        else $error("illegal status code");

    // rejected items never report a removed entry
    a_rej_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_DONE |-> o_removed_x == '0 && o_removed_y == '0)
        else $error("rejected item reports removed entry");

    a_empty_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_is_empty |-> o_head_x == '0 && o_head_y == '0)
        else $error("empty queue reports a head");

endmodule

bind binary_max_heap_queue_core bmhq_chk u_bmhq_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_status    (o_status),
    .o_removed_x (o_removed_x),
    .o_removed_y (o_removed_y),
    .o_head_x    (o_head_x),
    .o_head_y    (o_head_y),
    .o_is_empty  (o_is_empty)
);

`default_nettype wire

>>> bench/binary_max_heap_queue_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_max_heap_queue_core_tb
// Self-checking bench for the binary max-heap queue core. A heap model kept
// in the bench predicts status, removed entry, head, count and empty flag for
// every item. Directed items cover the extremes, equal-priority ordering and
// removes on an empty queue. Random traffic follows, then a backpressure
// stretch, a fill to capacity with rejected inserts, and a partial drain.
// ----------------------------------------------------------------------------

module binary_max_heap_queue_core_tb;
    import bmhq_pkg::*;

    localparam int CAPACITY = DEF_CAPACITY;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;
    localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;

    logic                     i_clk;
    logic                     i_rst_n = 1'b0;
    logic                     i_in_valid = 1'b0;
    logic                     o_in_ready;
    logic                     i_mode = MODE_INSERT;
    logic signed [DATA_W-1:0] i_entry_x = '0;
    logic signed [DATA_W-1:0] i_entry_y = '0;
    logic signed [DATA_W-1:0] i_entry_priority = '0;
    logic                     o_out_valid;
    logic                     i_out_ready = 1'b0;
    logic [1:0]               o_status;
    logic signed [DATA_W-1:0] o_removed_x;
    logic signed [DATA_W-1:0] o_removed_y;
    logic signed [DATA_W-1:0] o_head_x;
    logic signed [DATA_W-1:0] o_head_y;
    logic [COUNT_OUT_W-1:0]   o_entry_count;
    logic                     o_is_empty;

    // heap model
    logic signed [DATA_W-1:0] heap_x [CAPACITY];
    logic signed [DATA_W-1:0] heap_y [CAPACITY];
    logic signed [DATA_W-1:0] heap_pri [CAPACITY];
    int                       heap_size = 0;

    t_result results_due [$];
    int      err_count = 0;
    int      cycle_count = 0;
    int      hold_left = 0;
    bit      idle_off = 1'b0;

    binary_max_heap_queue_core #(
        .CAPACITY(CAPACITY)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_mode          (i_mode),
        .i_entry_x       (i_entry_x),
        .i_entry_y       (i_entry_y),
        .i_entry_priority(i_entry_priority),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_removed_x     (o_removed_x),
        .o_removed_y     (o_removed_y),
        .o_head_x        (o_head_x),
        .o_head_y        (o_head_y),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("binary_max_heap_queue_core: mismatch");
            $finish;
        end
    end

    // receiver: random stalls, long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (idle_off) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                $error("result with no item outstanding");
                err_count++;
            end else begin
                want = results_due.pop_front();
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    err_count++;
                end
                if (o_removed_x !== want.removed_x) begin
                    $error("removed_x: expected %0d, got %0d", want.removed_x, o_removed_x);
                    err_count++;
                end
                if (o_removed_y !== want.removed_y) begin
                    $error("removed_y: expected %0d, got %0d", want.removed_y, o_removed_y);
                    err_count++;
                end
                if (o_head_x !== want.head_x) begin
                    $error("head_x: expected %0d, got %0d", want.head_x, o_head_x);
                    err_count++;
                end
                if (o_head_y !== want.head_y) begin
                    $error("head_y: expected %0d, got %0d", want.head_y, o_head_y);
                    err_count++;
                end
                if (o_entry_count !== want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, o_entry_count);
                    err_count++;
                end
                if (o_is_empty !== want.empty) begin
                    $error("is_empty: expected %0d, got %0d", want.empty, o_is_empty);
                    err_count++;
                end
            end
        end
    end

    task automatic heap_swap(input int a, input int b);
        logic signed [DATA_W-1:0] t;
        t = heap_x[a];   heap_x[a] = heap_x[b];     heap_x[b] = t;
        t = heap_y[a];   heap_y[a] = heap_y[b];     heap_y[b] = t;
        t = heap_pri[a]; heap_pri[a] = heap_pri[b]; heap_pri[b] = t;
    endtask

    task automatic heap_apply(input logic mode, input logic signed [DATA_W-1:0] x,
                              input logic signed [DATA_W-1:0] y,
                              input logic signed [DATA_W-1:0] pri, output t_result res);
        int node;
        int parent;
        int kid;
        bit moving;
        res = '0;
        res.status = ST_DONE;
        if (mode == MODE_INSERT) begin
            if (heap_size >= CAPACITY) begin
                res.status = ST_FULL;
            end else begin
                node = heap_size;
                heap_x[node] = x;
                heap_y[node] = y;
                heap_pri[node] = pri;
                // ties rise: newer entry goes above an equal parent
                moving = 1'b1;
                while (moving && node > 0) begin
                    parent = (node - 1) / 2;
                    if (heap_pri[parent] > heap_pri[node]) begin
                        moving = 1'b0;
                    end else begin
                        heap_swap(parent, node);
                        node = parent;
                    end
                end
                heap_size++;
            end
        end else if (heap_size == 0) begin
            res.status = ST_EMPTY;
        end else begin
            res.removed_x = heap_x[0];
            res.removed_y = heap_y[0];
            heap_size--;
            heap_x[0] = heap_x[heap_size];
            heap_y[0] = heap_y[heap_size];
            heap_pri[0] = heap_pri[heap_size];
            node = 0;
            kid = 1;
            moving = 1'b1;
            while (moving && kid < heap_size) begin
                // right child only when strictly greater
                if (kid + 1 < heap_size && heap_pri[kid] < heap_pri[kid + 1]) kid++;
                if (heap_pri[node] >= heap_pri[kid]) begin
                    moving = 1'b0;
                end else begin
                    heap_swap(node, kid);
                    node = kid;
                    kid = 2 * node + 1;
                end
            end
        end
        if (heap_size > 0) begin
            res.head_x = heap_x[0];
            res.head_y = heap_y[0];
        end
        res.count = COUNT_OUT_W'(heap_size);
        res.empty = (heap_size == 0);
    endtask

    function automatic logic signed [DATA_W-1:0] rand_priority();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick < 4) return $signed(DATA_W'($urandom_range(0, 8))) - 4;
        if (pick < 6) return $urandom;
        case ($urandom_range(0, 3))
            0:       return INT_MAX;
            1:       return INT_MIN;
            2:       return '0;
            default: return -1;
        endcase
    endfunction

    task automatic send_item(input logic mode, input logic signed [DATA_W-1:0] x,
                             input logic signed [DATA_W-1:0] y,
                             input logic signed [DATA_W-1:0] pri);
        int gap;
        t_result want;
        gap = 0;
        if (!idle_off) begin
            while ($urandom_range(0, 99) < 26) gap++;
        end
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_mode <= mode;
        i_entry_x <= x;
        i_entry_y <= y;
        i_entry_priority <= pri;
        do @(posedge i_clk); while (!o_in_ready);
        heap_apply(mode, x, y, pri, want);
        results_due.push_back(want);
    endtask

    task automatic send_random(input logic mode);
        send_item(mode, $urandom, $urandom, rand_priority());
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (results_due.size() != 0);
    endtask

    task automatic test_directed();
        send_item(MODE_REMOVE, INT_MAX, INT_MIN, INT_MAX);    // remove on empty
        send_item(MODE_INSERT, INT_MIN, INT_MAX, 0);
        send_item(MODE_INSERT, INT_MAX, INT_MIN, INT_MAX);
        send_item(MODE_INSERT, 0, -1, INT_MIN);
        send_item(MODE_INSERT, -1, 0, INT_MAX);               // equal top priority, newer wins
        send_item(MODE_INSERT, 1, 2, 5);
        send_item(MODE_INSERT, 3, 4, 5);
        send_item(MODE_INSERT, -1, -1, -1);
        repeat (8) send_item(MODE_REMOVE, -1, -1, -1);        // last one hits empty
        // four equal keys: sift-down must keep the left child on ties
        send_item(MODE_INSERT, 10, 10, 7);
        send_item(MODE_INSERT, 11, 11, 7);
        send_item(MODE_INSERT, 12, 12, 7);
        send_item(MODE_INSERT, 13, 13, 7);
        repeat (2) send_item(MODE_REMOVE, 0, 0, 0);
    endtask

    task automatic test_random_mix();
        repeat (100) begin
            send_random(($urandom_range(0, 99) < 45) ? MODE_REMOVE : MODE_INSERT);
        end
    endtask

    task automatic test_backpressure();
        idle_off = 1'b1;
        hold_left = 500;
        repeat (40) begin
            send_random(($urandom_range(0, 99) < 30) ? MODE_REMOVE : MODE_INSERT);
        end
        idle_off = 1'b0;
        wait_drained();
    endtask

    task automatic test_fill_to_capacity();
        int sent;
        sent = 0;
        idle_off = 1'b1;
        while (heap_size < CAPACITY) begin
            if (sent == 300) idle_off = 1'b0;
            send_random(MODE_INSERT);
            sent++;
        end
        idle_off = 1'b0;
        repeat (8) send_random(MODE_INSERT);    // rejected, store full
        repeat (30) begin
            send_random(($urandom_range(0, 99) < 50) ? MODE_REMOVE : MODE_INSERT);
        end
    endtask

    task automatic test_partial_drain();
        repeat (60) send_random(MODE_REMOVE);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random_mix();
        test_backpressure();
        test_fill_to_capacity();
        test_partial_drain();
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (err_count == 0 && results_due.size() == 0) begin
            $display("binary_max_heap_queue_core: match");
        end else begin
            $display("binary_max_heap_queue_core: mismatch");
        end
        $finish;
    end

endmodule

>>> files.f
design/bmhq_pkg.sv
design/bmhq_mem.sv
design/bmhq_ctrl.sv
design/binary_max_heap_queue_core.sv
design/bmhq_chk.sv
bench/binary_max_heap_queue_core_tb.sv
